// ----- design/qsp_pkg.sv -----
// Package for the quantity string parser: phase and radix codes, status codes,
// the front-to-back item struct and character helper functions. No dependencies.
package qsp_pkg;

  typedef enum logic [3:0] {
    PH_START, PH_LEAD, PH_SIGN, PH_ZERO, PH_ZERO_WS,
    PH_PFX_FIRST, PH_PFX_ZERO, PH_DIGITS, PH_POST, PH_DONE
  } phase_e;

  typedef enum logic [1:0] {RAD_DEC, RAD_OCT, RAD_HEX, RAD_BIN} radix_e;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_DIG   = 3'd1;
  localparam logic [2:0] ST_BAD_PFX  = 3'd2;
  localparam logic [2:0] ST_EMPTY_PF = 3'd3;
  localparam logic [2:0] ST_BAD_SFX  = 3'd4;
  localparam logic [2:0] ST_LONG_SFX = 3'd5;
  localparam logic [2:0] ST_RANGE    = 3'd6;

  // Classified item handed from the front to the back.
  typedef struct packed {
    logic [7:0] char_code;
    logic       has_char;
    logic       last_char;
    logic       signed_mode;
    logic       is_blank;
    logic       is_dec;
    logic [4:0] digit;      // hex digit value, 16 when the byte is no hex digit
    logic [7:0] lower;
  } item_t;

  function automatic logic blank_f(input logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [7:0] lower_f(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

endpackage

// ----- design/qsp_front.sv -----
// Front stage of the quantity string parser: accepts items and classifies the byte.
// Uses qsp_pkg.
module qsp_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           stall_o,
  input  logic [7:0]     char_code_i,
  input  logic           has_char_i,
  input  logic           last_char_i,
  input  logic           signed_mode_i,
  output logic           item_valid_o,
  input  logic           item_pop_i,
  output qsp_pkg::item_t item_o
);
  logic           vld_q, vld_d;
  qsp_pkg::item_t item_q;
  qsp_pkg::item_t cls;
  logic [7:0]     low;

  always_comb begin
    low = qsp_pkg::lower_f(char_code_i);
    cls.char_code   = char_code_i;
    cls.has_char    = has_char_i;
    cls.last_char   = last_char_i;
    cls.signed_mode = signed_mode_i;
    cls.is_blank    = qsp_pkg::blank_f(char_code_i);
    cls.is_dec      = char_code_i >= 8'h30 && char_code_i <= 8'h39;
    cls.lower       = low;
    if (cls.is_dec) begin
      cls.digit = {1'b0, char_code_i[3:0]};
    end else if (low >= 8'h61 && low <= 8'h66) begin
      cls.digit = 5'(low - 8'h57);
    end else begin
      cls.digit = 5'd16;
    end
  end

  assign stall_o      = vld_q && !item_pop_i;
  assign item_valid_o = vld_q;
  assign item_o       = item_q;
  assign vld_d        = (valid_i && !stall_o) || (vld_q && !item_pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      item_q <= cls;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && !item_pop_i |=> vld_q && $stable(item_q))
    else $error("queued item lost while back stage stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_o && item_o.is_dec |-> item_o.digit < 5'd10)
    else $error("decimal byte classified with bad digit");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_o && item_o.is_blank |-> item_o.digit == 5'd16)
    else $error("blank byte classified as digit");
endmodule

// ----- design/qsp_back.sv -----
// Back stage of the quantity string parser: phase machine, accumulator and final
// evaluation with suffix scaling, into an output register. Uses qsp_pkg.
module qsp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           item_valid_i,
  output logic           item_pop_o,
  input  qsp_pkg::item_t item_i,
  output logic           valid_o,
  input  logic           stall_i,
  output logic [63:0]    value_o,
  output logic [2:0]     status_o
);
  localparam logic [63:0] TopBit  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] AllOnes = '1;

  qsp_pkg::phase_e phase_q, phase_d, ph_mid;
  qsp_pkg::radix_e radix_q, radix_d;
  logic [63:0] acc_q, acc_d;
  logic neg_q, neg_d, rng_q, rng_d, mode_q, mode_d;
  logic [7:0] lnc_q, lnc_d;
  logic [1:0] span_q, span_d;
  logic [2:0] pst_q, pst_d;
  logic ovalid_q;
  logic [63:0] oval_q, val_c;
  logic [2:0] ost_q, st_c;
  logic take;

  logic [4:0] rbase, dig;
  logic [67:0] prod;
  logic [63:0] r;
  logic ovf;
  logic [4:0] k;
  logic [63:0] lim;
  logic [7:0] c, l;

  assign item_pop_o = item_valid_i && (!ovalid_q || !stall_i);
  assign take = item_pop_o;
  assign c = item_i.char_code;
  assign l = item_i.lower;

  // Next state: one character per item.
  always_comb begin
    phase_d = phase_q; radix_d = radix_q; acc_d = acc_q; neg_d = neg_q;
    rng_d = rng_q; mode_d = mode_q; lnc_d = lnc_q; span_d = span_q; pst_d = pst_q;
    ph_mid = phase_q;
    if (phase_q == qsp_pkg::PH_START) begin
      mode_d = item_i.signed_mode;
      ph_mid = qsp_pkg::PH_LEAD;
    end
    phase_d = ph_mid;
    case (radix_q)
      qsp_pkg::RAD_OCT: rbase = 5'd8;
      qsp_pkg::RAD_HEX: rbase = 5'd16;
      qsp_pkg::RAD_BIN: rbase = 5'd2;
      default:          rbase = 5'd10;
    endcase
    dig = (item_i.digit < rbase) ? item_i.digit : 5'd16;
    // Octal radix for a run that follows a lone zero.
    if (ph_mid == qsp_pkg::PH_ZERO && item_i.is_dec) begin
      rbase = 5'd8;
      dig = (item_i.digit < 5'd8) ? item_i.digit : 5'd16;
    end
    case (rbase)
      5'd8:    prod = {1'b0, acc_q, 3'b0};
      5'd16:   prod = {acc_q, 4'b0};
      5'd2:    prod = {3'b0, acc_q, 1'b0};
      default: prod = {1'b0, acc_q, 3'b0} + {3'b0, acc_q, 1'b0};
    endcase
    prod = prod + 68'(dig[3:0]);
    if (item_i.has_char) begin
      case (ph_mid)
        qsp_pkg::PH_LEAD: begin
          if (!item_i.is_blank) begin
            if (c == 8'h2B) phase_d = qsp_pkg::PH_SIGN;
            else if (c == 8'h2D) begin neg_d = 1'b1; phase_d = qsp_pkg::PH_SIGN; end
            else if (item_i.is_dec) begin
              if (c == 8'h30) phase_d = qsp_pkg::PH_ZERO;
              else begin acc_d = 64'(item_i.digit); phase_d = qsp_pkg::PH_DIGITS; end
            end else begin pst_d = qsp_pkg::ST_NO_DIG; phase_d = qsp_pkg::PH_DONE; end
          end
        end
        qsp_pkg::PH_SIGN: begin
          if (item_i.is_dec) begin
            if (c == 8'h30) phase_d = qsp_pkg::PH_ZERO;
            else begin acc_d = 64'(item_i.digit); phase_d = qsp_pkg::PH_DIGITS; end
          end else begin pst_d = qsp_pkg::ST_NO_DIG; phase_d = qsp_pkg::PH_DONE; end
        end
        qsp_pkg::PH_ZERO: begin
          if (item_i.is_dec) begin
            radix_d = qsp_pkg::RAD_OCT;
            phase_d = qsp_pkg::PH_DIGITS;
            if (dig != 5'd16) acc_d = 64'(dig);
            else begin
              acc_d = '0; phase_d = qsp_pkg::PH_POST;
              lnc_d = c; span_d = 2'd1;
            end
          end else if (item_i.is_blank) phase_d = qsp_pkg::PH_ZERO_WS;
          else if (l == 8'h67 || l == 8'h6D || l == 8'h6B) begin
            acc_d = '0; phase_d = qsp_pkg::PH_POST; lnc_d = c; span_d = 2'd1;
          end else if (l == 8'h78) begin
            radix_d = qsp_pkg::RAD_HEX; phase_d = qsp_pkg::PH_PFX_FIRST;
          end else if (l == 8'h6F) begin
            radix_d = qsp_pkg::RAD_OCT; phase_d = qsp_pkg::PH_PFX_FIRST;
          end else if (l == 8'h62) begin
            radix_d = qsp_pkg::RAD_BIN; phase_d = qsp_pkg::PH_PFX_FIRST;
          end else begin pst_d = qsp_pkg::ST_BAD_PFX; phase_d = qsp_pkg::PH_DONE; end
        end
        qsp_pkg::PH_ZERO_WS: begin
          if (!item_i.is_blank) begin
            pst_d = qsp_pkg::ST_BAD_PFX; phase_d = qsp_pkg::PH_DONE;
          end
        end
        qsp_pkg::PH_PFX_FIRST: begin
          if (c == 8'h30) begin acc_d = '0; phase_d = qsp_pkg::PH_PFX_ZERO; end
          else if (item_i.is_blank || c == 8'h2B || c == 8'h2D) begin
            pst_d = qsp_pkg::ST_EMPTY_PF; phase_d = qsp_pkg::PH_DONE;
          end else if (dig != 5'd16) begin
            acc_d = 64'(dig); phase_d = qsp_pkg::PH_DIGITS;
          end else begin pst_d = qsp_pkg::ST_NO_DIG; phase_d = qsp_pkg::PH_DONE; end
        end
        qsp_pkg::PH_PFX_ZERO, qsp_pkg::PH_DIGITS: begin
          if (ph_mid == qsp_pkg::PH_PFX_ZERO &&
              (l == 8'h78 || l == 8'h6F || l == 8'h62)) begin
            pst_d = qsp_pkg::ST_EMPTY_PF; phase_d = qsp_pkg::PH_DONE;
          end else begin
            phase_d = qsp_pkg::PH_DIGITS;
            if (dig != 5'd16) begin
              if (rng_q || prod[67:64] != 4'd0) begin
                rng_d = 1'b1; acc_d = AllOnes;
              end else acc_d = prod[63:0];
            end else begin
              phase_d = qsp_pkg::PH_POST;
              if (!item_i.is_blank) begin
                lnc_d = c; span_d = 2'd1;
              end
            end
          end
        end
        qsp_pkg::PH_POST: begin
          if (!item_i.is_blank) begin
            lnc_d = c;
            if (span_q != 2'd2) span_d = span_q + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Final evaluation from the state after this item.
  always_comb begin
    r = acc_d; ovf = rng_d; k = 5'd0; lim = '0;
    val_c = '0; st_c = qsp_pkg::ST_OK;
    if (!ovf) begin
      if (!mode_d) begin
        if (neg_d) begin
          if (r == 64'd1 && span_d == 2'd0) r = AllOnes;
          else ovf = 1'b1;
        end
      end else if (neg_d && r == TopBit) begin
        r = acc_d;
      end else if (r >= TopBit) ovf = 1'b1;
      else if (neg_d) r = 64'd0 - r;
    end
    case (qsp_pkg::lower_f(lnc_d))
      8'h67:   k = 5'd30;
      8'h6D:   k = 5'd20;
      8'h6B:   k = 5'd10;
      default: k = 5'd0;
    endcase
    case (phase_d)
      qsp_pkg::PH_SIGN:      st_c = qsp_pkg::ST_NO_DIG;
      qsp_pkg::PH_PFX_FIRST: st_c = qsp_pkg::ST_EMPTY_PF;
      qsp_pkg::PH_DONE:      st_c = pst_d;
      qsp_pkg::PH_PFX_ZERO, qsp_pkg::PH_DIGITS, qsp_pkg::PH_POST: begin
        if (span_d == 2'd0) begin
          val_c = r; st_c = ovf ? qsp_pkg::ST_RANGE : qsp_pkg::ST_OK;
        end else if (k == 5'd0) begin
          val_c = r; st_c = qsp_pkg::ST_BAD_SFX;
        end else begin
          if (!ovf) begin
            if (mode_d) begin
              if (r != 64'd0 && r < TopBit) ovf = r > ((TopBit - 64'd1) >> k);
              else if (r != 64'd0) begin
                lim = 64'd0 - (64'd1 << (6'd63 - 6'(k)));
                ovf = r < lim;
              end
            end else ovf = r > (AllOnes >> k);
          end
          val_c = r << k;
          st_c = (span_d == 2'd2) ? qsp_pkg::ST_LONG_SFX :
                 (ovf ? qsp_pkg::ST_RANGE : qsp_pkg::ST_OK);
        end
      end
      default: st_c = qsp_pkg::ST_OK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= qsp_pkg::PH_START; radix_q <= qsp_pkg::RAD_DEC; acc_q <= '0;
      neg_q <= 1'b0; rng_q <= 1'b0; mode_q <= 1'b0; lnc_q <= '0;
      span_q <= '0; pst_q <= '0; ovalid_q <= 1'b0;
    end else begin
      if (ovalid_q && !stall_i) ovalid_q <= 1'b0;
      if (take) begin
        if (item_i.last_char) begin
          ovalid_q <= 1'b1;
          phase_q <= qsp_pkg::PH_START; radix_q <= qsp_pkg::RAD_DEC; acc_q <= '0;
          neg_q <= 1'b0; rng_q <= 1'b0; mode_q <= 1'b0; lnc_q <= '0;
          span_q <= '0; pst_q <= '0;
        end else begin
          phase_q <= phase_d; radix_q <= radix_d; acc_q <= acc_d; neg_q <= neg_d;
          rng_q <= rng_d; mode_q <= mode_d; lnc_q <= lnc_d; span_q <= span_d;
          pst_q <= pst_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && item_i.last_char) begin
      oval_q <= val_c; ost_q <= st_c;
    end
  end

  assign valid_o  = ovalid_q;
  assign value_o  = oval_q;
  assign status_o = ost_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && item_i.last_char |=> valid_o && phase_q == qsp_pkg::PH_START)
    else $error("last item did not emit a result and restart");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(value_o) && $stable(status_o))
    else $error("held result changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rng_q |-> acc_q == AllOnes)
    else $error("saturated accumulator not all ones");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> status_o <= qsp_pkg::ST_RANGE)
    else $error("undefined status code");
endmodule

// ----- design/quantity_string_parser_unit.sv -----
// Quantity string parser: one byte per input item, one 64-bit value and status
// per string. Depends on qsp_pkg, qsp_front and qsp_back.
//
// Input channel: valid_i/stall_o with char_code_i, has_char_i, last_char_i and
// signed_mode_i. signed_mode_i is sampled on the first item of a string. An
// item with has_char_i low carries no byte, so an empty string is one item
// with has_char_i low and last_char_i high.
// Output channel: valid_o/stall_i with value_o and status_o; one result is
// produced for each item marked last, none for the others.
// Throughput is one item per cycle while the receiver does not stall. An item
// is held in the front register, and the back stage loads the result of a last
// item into the output register at the same edge at which it takes that item,
// so valid_o rises in the cycle after the back stage takes the last item.
// When the receiver stalls, the output register holds its result and the back
// stage takes no further item until that result is accepted; the front
// register then fills and stall_o rises.
// Reset empties the front register, restarts the back stage and clears the
// output valid flag; the next item starts a new string.
module quantity_string_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [7:0]  char_code_i,
  input  logic        has_char_i,
  input  logic        last_char_i,
  input  logic        signed_mode_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [63:0] value_o,
  output logic [2:0]  status_o
);
  qsp_pkg::item_t item;
  logic item_valid, item_pop;

  qsp_front u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o, .char_code_i, .has_char_i,
    .last_char_i, .signed_mode_i,
    .item_valid_o(item_valid), .item_pop_i(item_pop), .item_o(item)
  );

  qsp_back u_back (
    .clk_i, .rst_ni,
    .item_valid_i(item_valid), .item_pop_o(item_pop), .item_i(item),
    .valid_o, .stall_i, .value_o, .status_o
  );
endmodule
